// ----- rtl/core/ncc_pkg.sv -----
// Shared types and constants for the nearest-center cost unit.
// No dependencies.
`timescale 1ns / 1ps

package ncc_pkg;

  localparam int DEF_MAX_CENTERS = 64;
  localparam int DEF_MAX_DIMS    = 128;
  localparam int DEF_COORD_BITS  = 16;

  localparam int ACC_W  = 39;
  localparam int COST_W = 63;
  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam int CIDX_W = 6;
  localparam int DIDX_W = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int NDIMS_W    = 8;
  localparam int NCENT_W    = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIMS    = 2'd0,
    CFG_NUM_CENTERS = 2'd1
  } cfg_reg_e;

  localparam logic FUNC_CENTER_WR = 1'b0;
  localparam logic FUNC_POINT     = 1'b1;

  typedef struct packed {
    logic load_x;
    logic wr_center;
    logic issue;
    logic use_min;
    logic emit;
    logic last;
  } ncc_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } ncc_sts_t;

endpackage

// ----- rtl/core/nearest_center_cost_unit.sv -----
// Top level of the nearest-center (k-means) cost unit.
// Depends on ncc_pkg, ncc_ctrl, ncc_datapath, ncc_ram.
//
//  channel  direction  handshake                 payload
//  in       to block   in_valid_i / in_stall_o   func, center_index, dim_index,
//                                                coord_value, last_point
//  out      from block out_valid_o / out_stall_i point_min_distance, total_cost, is_last
//  cfg      to block   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each point coordinate runs the single square-and-add pipeline, which walks every
// center once per coordinate and then drains before the next item is taken.
// A point's final coordinate adds a finish step for the cost update and result load.
// Async active-low reset clears control, accumulator valid bits and total cost;
// the center store is not cleared. A stalled result holds the unit only when
// the next result is ready to load.
`timescale 1ns / 1ps

module nearest_center_cost_unit
  import ncc_pkg::*;
#(
  parameter int MAX_CENTERS = DEF_MAX_CENTERS,
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [CIDX_W-1:0]            center_index_i,
  input  logic [DIDX_W-1:0]            dim_index_i,
  input  logic signed [COORD_BITS-1:0] coord_value_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ACC_W-1:0]             point_min_distance_o,
  output logic [COST_W-1:0]            total_cost_o,
  output logic                         is_last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int CW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  ncc_cmd_t      cmd;
  ncc_sts_t      sts;
  logic [CW-1:0] walk_center;
  logic [DW-1:0] walk_dim;

  ncc_ctrl #(
    .MAX_CENTERS (MAX_CENTERS),
    .MAX_DIMS    (MAX_DIMS),
    .CW          (CW),
    .DW          (DW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .last_point_i  (last_point_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .walk_center_o (walk_center),
    .walk_dim_o    (walk_dim)
  );

  ncc_datapath #(
    .MAX_CENTERS (MAX_CENTERS),
    .MAX_DIMS    (MAX_DIMS),
    .COORD_BITS  (COORD_BITS),
    .CW          (CW),
    .DW          (DW)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .walk_center_i        (walk_center),
    .walk_dim_i           (walk_dim),
    .center_index_i       (center_index_i),
    .dim_index_i          (dim_index_i),
    .coord_value_i        (coord_value_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .point_min_distance_o (point_min_distance_o),
    .total_cost_o         (total_cost_o),
    .is_last_o            (is_last_o)
  );

endmodule

// ----- rtl/core/ncc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ncc_ram #(
  parameter int   WIDTH = 16,
  parameter int   DEPTH = 64,
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ncc_ctrl.sv -----
// Controller: config registers, item handshake, dimension and center walk FSM.
// Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_ctrl
  import ncc_pkg::*;
#(
  parameter int MAX_CENTERS = DEF_MAX_CENTERS,
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int CW          = 6,
  parameter int DW          = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic                  last_point_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ncc_sts_t              sts_i,
  output ncc_cmd_t              cmd_o,
  output logic [CW-1:0]         walk_center_o,
  output logic [DW-1:0]         walk_dim_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [NDIMS_W-1:0]   num_dims_q, num_dims_d;
  logic [NCENT_W-1:0]   num_centers_q, num_centers_d;
  logic [NDIMS_W-1:0]   nd_eff;
  logic [NCENT_W-1:0]   nc_eff;
  logic [DW-1:0]        dcnt_q, dcnt_d;
  logic [CW-1:0]        ctr_q, ctr_d;
  logic                 final_q, final_d;
  logic                 last_q, last_d;
  logic                 accept;
  logic                 cfg_we;
  logic                 ctr_end;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign ctr_end     = (ctr_q == CW'(MAX_CENTERS - 1));

  always_comb begin
    num_dims_d    = num_dims_q;
    num_centers_d = num_centers_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_NUM_DIMS:    num_dims_d    = cfg_data_i[NDIMS_W-1:0];
        CFG_NUM_CENTERS: num_centers_d = cfg_data_i[NCENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_dims_q == '0) begin
      nd_eff = NDIMS_W'(1);
    end else if (32'(num_dims_q) > MAX_DIMS) begin
      nd_eff = NDIMS_W'(MAX_DIMS);
    end else begin
      nd_eff = num_dims_q;
    end
    if (num_centers_q == '0) begin
      nc_eff = NCENT_W'(1);
    end else if (32'(num_centers_q) > MAX_CENTERS) begin
      nc_eff = NCENT_W'(MAX_CENTERS);
    end else begin
      nc_eff = num_centers_q;
    end
  end

  always_comb begin
    state_d = state_q;
    dcnt_d  = dcnt_q;
    ctr_d   = ctr_q;
    final_d = final_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.last = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_POINT) begin
            cmd_o.load_x = 1'b1;
            ctr_d   = '0;
            final_d = (32'(dcnt_q) + 1 >= 32'(nd_eff));
            last_d  = last_point_i;
            state_d = ST_WALK;
          end else begin
            cmd_o.wr_center = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd_o.issue   = 1'b1;
        cmd_o.use_min = (32'(ctr_q) < 32'(nc_eff));
        ctr_d = ctr_q + 1'b1;
        if (ctr_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          if (final_q) begin
            state_d = ST_FINISH;
          end else begin
            dcnt_d  = dcnt_q + 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          dcnt_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign walk_center_o = ctr_q;
  assign walk_dim_o    = dcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      num_dims_q    <= NDIMS_W'(1);
      num_centers_q <= NCENT_W'(1);
      dcnt_q        <= '0;
      ctr_q         <= '0;
      final_q       <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      num_dims_q    <= num_dims_d;
      num_centers_q <= num_centers_d;
      dcnt_q        <= dcnt_d;
      ctr_q         <= ctr_d;
      final_q       <= final_d;
      last_q        <= last_d;
    end
  end

`ifndef SYNTH
  a_walk_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && !ctr_end) |=> (cmd_o.issue && ctr_q == $past(ctr_q) + 1'b1))
    else $error("center walk skipped or stopped early");
  a_dim_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_x |-> (32'(dcnt_q) < 32'(nd_eff) || $past(num_dims_q) != num_dims_q
                      || 32'(dcnt_q) < MAX_DIMS))
    else $error("dimension counter out of range");
  a_emit_resets_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (dcnt_q == '0 && state_q == ST_IDLE))
    else $error("point did not close after emit");
`endif

endmodule

// ----- rtl/core/ncc_datapath.sv -----
// Datapath: center store, accumulator store, square-and-add pipeline, min and cost.
// Depends on ncc_pkg and ncc_ram.
`timescale 1ns / 1ps

module ncc_datapath
  import ncc_pkg::*;
#(
  parameter int MAX_CENTERS = DEF_MAX_CENTERS,
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int CW          = 6,
  parameter int DW          = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ncc_cmd_t                     cmd_i,
  output ncc_sts_t                     sts_o,
  input  logic [CW-1:0]                walk_center_i,
  input  logic [DW-1:0]                walk_dim_i,
  input  logic [CIDX_W-1:0]            center_index_i,
  input  logic [DIDX_W-1:0]            dim_index_i,
  input  logic signed [COORD_BITS-1:0] coord_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ACC_W-1:0]             point_min_distance_o,
  output logic [COST_W-1:0]            total_cost_o,
  output logic                         is_last_o
);

  localparam int AW     = CW + DW;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SQX_W  = (SQ_W > ACC_W) ? SQ_W : ACC_W;

  // center store
  logic                  cs_we;
  logic [AW-1:0]         cs_waddr;
  logic [COORD_BITS-1:0] cs_rdata;

  assign cs_we    = cmd_i.wr_center && (32'(center_index_i) < MAX_CENTERS)
                    && (32'(dim_index_i) < MAX_DIMS);
  assign cs_waddr = {CW'(center_index_i), DW'(dim_index_i)};

  ncc_ram #(
    .WIDTH (COORD_BITS),
    .DEPTH (2 ** AW)
  ) u_center_ram (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (cs_waddr),
    .wdata_i (coord_value_i),
    .raddr_i ({walk_center_i, walk_dim_i}),
    .rdata_o (cs_rdata)
  );

  // accumulator store, cleared through valid bits
  logic                   acc_we;
  logic [CW-1:0]          acc_waddr;
  logic [ACC_W-1:0]       acc_wdata;
  logic [ACC_W-1:0]       acc_rdata;
  logic [MAX_CENTERS-1:0] acc_vld_q, acc_vld_d;

  ncc_ram #(
    .WIDTH (ACC_W),
    .DEPTH (2 ** CW)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (walk_center_i),
    .rdata_o (acc_rdata)
  );

  logic signed [COORD_BITS-1:0] x_q;

  logic                     s1_vld_q, s1_min_q, s1_accv_q;
  logic [CW-1:0]            s1_c_q;
  logic                     s2_vld_q, s2_min_q;
  logic [CW-1:0]            s2_c_q;
  logic signed [DIFF_W-1:0] s2_diff_q;
  logic [ACC_W-1:0]         s2_acc_q;
  logic                     s3_vld_q, s3_min_q;
  logic [CW-1:0]            s3_c_q;
  logic [SQ_W-1:0]          s3_sq_q;
  logic [ACC_W-1:0]         s3_acc_q;

  logic signed [DIFF_W-1:0] diff;
  logic signed [SQ_W-1:0]   sq_full;
  logic [SQX_W-1:0]         sq_ext;
  logic [ACC_W-1:0]         sq_sat;
  logic [ACC_W:0]           acc_sum;

  logic                     best_vld_q, best_vld_d;
  logic [ACC_W-1:0]         best_q, best_d;
  logic [COST_W-1:0]        cost_q, cost_d, cost_new;
  logic [COST_W:0]          cost_sum;

  logic                     out_valid_q, out_valid_d;
  logic [ACC_W-1:0]         out_min_q;
  logic [COST_W-1:0]        out_cost_q;
  logic                     out_last_q;

  assign diff    = $signed({x_q[COORD_BITS-1], x_q})
                   - $signed({cs_rdata[COORD_BITS-1], cs_rdata});
  assign sq_full = s2_diff_q * s2_diff_q;
  assign sq_ext  = SQX_W'(s3_sq_q);
  assign sq_sat  = (sq_ext > SQX_W'(ACC_MAX)) ? ACC_MAX : sq_ext[ACC_W-1:0];
  assign acc_sum = {1'b0, s3_acc_q} + {1'b0, sq_sat};

  assign acc_we    = s3_vld_q;
  assign acc_waddr = s3_c_q;
  assign acc_wdata = (acc_sum >= {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];

  always_comb begin
    acc_vld_d = acc_vld_q;
    if (cmd_i.emit) begin
      acc_vld_d = '0;
    end else if (acc_we) begin
      acc_vld_d[acc_waddr] = 1'b1;
    end
  end

  always_comb begin
    best_vld_d = best_vld_q;
    best_d     = best_q;
    if (cmd_i.load_x) begin
      best_vld_d = 1'b0;
    end else if (s3_vld_q && s3_min_q && (!best_vld_q || acc_wdata < best_q)) begin
      best_vld_d = 1'b1;
      best_d     = acc_wdata;
    end
  end

  assign cost_sum = {1'b0, cost_q} + (COST_W + 1)'(best_q);
  assign cost_new = (cost_sum >= {1'b0, COST_MAX}) ? COST_MAX : cost_sum[COST_W-1:0];

  always_comb begin
    cost_d      = cost_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.emit) begin
      cost_d      = cmd_i.last ? '0 : cost_new;
      out_valid_d = 1'b1;
    end
  end

  assign sts_o.busy     = s1_vld_q || s2_vld_q || s3_vld_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      acc_vld_q   <= '0;
      best_vld_q  <= 1'b0;
      cost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_vld_q    <= cmd_i.issue;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      acc_vld_q   <= acc_vld_d;
      best_vld_q  <= best_vld_d;
      cost_q      <= cost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= coord_value_i;
    end
    s1_c_q    <= walk_center_i;
    s1_min_q  <= cmd_i.use_min;
    s1_accv_q <= acc_vld_q[walk_center_i];
    s2_c_q    <= s1_c_q;
    s2_min_q  <= s1_min_q;
    s2_diff_q <= diff;
    s2_acc_q  <= s1_accv_q ? acc_rdata : '0;
    s3_c_q    <= s2_c_q;
    s3_min_q  <= s2_min_q;
    s3_sq_q   <= $unsigned(sq_full);
    s3_acc_q  <= s2_acc_q;
    best_q    <= best_d;
    if (cmd_i.emit) begin
      out_min_q  <= best_q;
      out_cost_q <= cost_new;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign point_min_distance_o = out_min_q;
  assign total_cost_o         = out_cost_q;
  assign is_last_o            = out_last_q;

`ifndef SYNTH
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
  a_emit_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (acc_vld_q == '0))
    else $error("accumulators not cleared after point");
  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_x || cmd_i.emit) |-> !(s1_vld_q || s2_vld_q || s3_vld_q))
    else $error("pipeline busy at point start or emit");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for nearest_center_cost_unit: k-means cost, Q4.12 in, Q15.24
// distance and Q39.24 cost out. Depends on ncc_pkg and the unit's RTL; predicts every
// result with its own center/accumulator model and checks results in order.
`timescale 1ns / 1ps

module tb
  import ncc_pkg::*;
;

  localparam int CW            = DEF_COORD_BITS;
  localparam int MAX_C         = DEF_MAX_CENTERS;
  localparam int MAX_D         = DEF_MAX_DIMS;
  localparam int FILL_D        = 8;
  localparam int SETTLE_CYCLES = MAX_C + 16;
  localparam int HOLD_CYCLES   = 1500;
  localparam int RAND_ITEMS    = 1380;
  localparam int DRAIN_LIMIT   = 20000;
  localparam longint TIMEOUT_NS = 25_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    logic [ACC_W-1:0]  best_dist;
    logic [COST_W-1:0] cost;
    logic              last;
  } cost_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  func_i;
  logic [CIDX_W-1:0]     center_index_i;
  logic [DIDX_W-1:0]     dim_index_i;
  logic signed [CW-1:0]  coord_value_i;
  logic                  last_point_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ACC_W-1:0]      point_min_distance_o;
  logic [COST_W-1:0]     total_cost_o;
  logic                  is_last_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nearest_center_cost_unit DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .func_i               (func_i),
    .center_index_i       (center_index_i),
    .dim_index_i          (dim_index_i),
    .coord_value_i        (coord_value_i),
    .last_point_i         (last_point_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .point_min_distance_o (point_min_distance_o),
    .total_cost_o         (total_cost_o),
    .is_last_o            (is_last_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  // model state
  logic signed [CW-1:0] center_mem [MAX_C][MAX_D];
  logic [ACC_W-1:0]     dist_acc [MAX_C] = '{default: '0};
  int                   dim_pos = 0;
  logic [COST_W-1:0]    cost_sum = '0;
  logic [NDIMS_W-1:0]   dims_reg = NDIMS_W'(1);
  logic [NCENT_W-1:0]   cents_reg = NCENT_W'(1);
  cost_result_t         pending_costs [$];

  int          mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_tgl = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("nearest_center_cost_unit: mismatch");
    $finish;
  end

  function automatic int eff_dims(logic [NDIMS_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_D) return MAX_D;
    return int'(v);
  endfunction

  function automatic int eff_centers(logic [NCENT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_C) return MAX_C;
    return int'(v);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < 40)
      $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // One point coordinate: update all accumulators, close the point on its final dimension.
  function automatic void fold_coordinate(logic signed [CW-1:0] x, logic lp);
    int           nd;
    int           nc;
    longint       diff;
    logic [63:0]  sum;
    logic [ACC_W-1:0] best;
    cost_result_t r;
    nd = eff_dims(dims_reg);
    nc = eff_centers(cents_reg);
    for (int c = 0; c < MAX_C; c++) begin
      diff = longint'(x) - longint'(center_mem[c][dim_pos]);
      sum  = 64'(dist_acc[c]) + 64'(diff * diff);
      dist_acc[c] = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
    end
    if (dim_pos + 1 < nd) begin
      dim_pos++;
      return;
    end
    best = dist_acc[0];
    for (int c = 1; c < nc; c++)
      if (dist_acc[c] < best) best = dist_acc[c];
    sum = 64'(cost_sum) + 64'(best);
    cost_sum = (sum > 64'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
    r.best_dist = best;
    r.cost      = cost_sum;
    r.last      = lp;
    pending_costs.push_back(r);
    for (int c = 0; c < MAX_C; c++) dist_acc[c] = '0;
    dim_pos = 0;
    if (lp) cost_sum = '0;
  endfunction

  task automatic check_result();
    cost_result_t want;
    if (pending_costs.size() == 0) begin
      report_mismatch("unexpected result, total_cost", 64'(total_cost_o), 64'd0);
      return;
    end
    want = pending_costs.pop_front();
    if (point_min_distance_o !== want.best_dist)
      report_mismatch("point_min_distance", 64'(point_min_distance_o), 64'(want.best_dist));
    if (total_cost_o !== want.cost)
      report_mismatch("total_cost", 64'(total_cost_o), 64'(want.cost));
    if (is_last_o !== want.last)
      report_mismatch("is_last", 64'(is_last_o), 64'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_NUM_DIMS) dims_reg = cfg_data_i;
        else if (cfg_index_i == CFG_NUM_CENTERS) cents_reg = cfg_data_i[NCENT_W-1:0];
      end
      if (in_valid_i && !in_stall_o) begin
        if (func_i == FUNC_CENTER_WR) center_mem[center_index_i][dim_index_i] = coord_value_i;
        else fold_coordinate(coord_value_i, last_point_i);
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen   <= hold_tgl;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic set_idling(int unsigned snd, int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct <= rcv;
  endtask

  task automatic send_item(logic fn, logic [CIDX_W-1:0] ci, logic [DIDX_W-1:0] di,
                           logic signed [CW-1:0] x, logic lp);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    center_index_i <= ci;
    dim_index_i    <= di;
    coord_value_i  <= x;
    last_point_i   <= lp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_coord(logic signed [CW-1:0] x, logic lp);
    send_item(FUNC_POINT, CIDX_W'($urandom_range(63)), DIDX_W'($urandom_range(127)), x, lp);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // every center coordinate a point can reach is written before any point is sent
  task automatic test_center_fill();
    logic signed [CW-1:0] v;
    for (int d = 0; d < FILL_D; d++)
      for (int c = 0; c < MAX_C; c++) begin
        case (c)
          0:       v = COORD_MIN;
          1:       v = COORD_MAX;
          2:       v = '0;
          default: v = rand_coord();
        endcase
        send_item(FUNC_CENTER_WR, CIDX_W'(c), DIDX_W'(d), v, 1'($urandom_range(1)));
      end
  endtask

  task automatic test_reset_defaults();
    send_coord(COORD_MAX, 1'b0);
    send_coord(COORD_MIN, 1'b1);
    drain_results();
  endtask

  task automatic test_directed_extremes();
    write_reg(CFG_NUM_DIMS, 8'd2);
    write_reg(CFG_NUM_CENTERS, 8'd64);
    // last flag on a non-final dimension is ignored
    send_coord(COORD_MAX, 1'b1);
    send_coord(COORD_MIN, 1'b0);
    // center rewritten in the middle of a point
    send_coord('0, 1'b0);
    send_item(FUNC_CENTER_WR, CIDX_W'(63), DIDX_W'(1), COORD_MAX, 1'b0);
    send_coord(COORD_MAX, 1'b1);
    send_item(FUNC_POINT, '0, '0, COORD_MIN, 1'b0);
    send_item(FUNC_POINT, '1, '1, COORD_MIN, 1'b0);
    drain_results();
    write_reg(CFG_NUM_CENTERS, 8'd1);
    send_coord(COORD_MIN, 1'b0);
    send_coord(COORD_MAX, 1'b1);
    drain_results();
  endtask

  task automatic test_config_extremes();
    // out-of-range num_centers clamps to the maximum; bit 7 of num_centers is dropped
    write_reg(CFG_NUM_DIMS, 8'(FILL_D));
    write_reg(CFG_NUM_CENTERS, 8'd200);
    for (int d = 0; d < FILL_D; d++)
      send_coord(rand_coord(), (d == FILL_D - 1) ? 1'b1 : 1'($urandom_range(1)));
    drain_results();
    write_reg(CFG_SPARE_LO, 8'($urandom));
    write_reg(CFG_SPARE_HI, 8'd7);
    write_reg(CFG_NUM_DIMS, 8'd0);
    write_reg(CFG_NUM_CENTERS, 8'd128);
    send_coord(COORD_MIN, 1'b0);
    send_coord(COORD_MAX, 1'b1);
    drain_results();
    write_reg(CFG_NUM_DIMS, 8'(FILL_D));
    write_reg(CFG_NUM_CENTERS, 8'd0);
    for (int d = 0; d < FILL_D; d++)
      send_coord(rand_coord(), d == FILL_D - 1);
    drain_results();
  endtask

  task automatic test_input_backpressure();
    write_reg(CFG_NUM_DIMS, 8'd1);
    write_reg(CFG_NUM_CENTERS, 8'd3);
    set_idling(0, 0);
    hold_tgl <= ~hold_tgl;
    for (int p = 0; p < 30; p++)
      send_coord(rand_coord(), p == 29);
    drain_results();
  endtask

  task automatic run_random_burst(inout int count);
    int nd;
    int points;
    int r;
    r = $urandom_range(99);
    if (r < 3)       write_reg(CFG_NUM_DIMS, 8'(FILL_D));
    else if (r < 10) write_reg(CFG_NUM_DIMS, (r < 5) ? 8'd0 : 8'($urandom_range(4, FILL_D)));
    else             write_reg(CFG_NUM_DIMS, 8'($urandom_range(1, 6)));
    r = $urandom_range(99);
    if (r < 10)      write_reg(CFG_NUM_CENTERS, 8'($urandom_range(255)));
    else if (r < 20) write_reg(CFG_NUM_CENTERS, 8'd64);
    else             write_reg(CFG_NUM_CENTERS, 8'($urandom_range(1, 64)));
    if ($urandom_range(19) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
    nd = eff_dims(dims_reg);
    points = $urandom_range(2, 48) / nd;
    if (points < 1) points = 1;
    for (int p = 0; p < points; p++)
      for (int d = 0; d < nd; d++) begin
        if ($urandom_range(9) == 0) begin
          send_item(FUNC_CENTER_WR, CIDX_W'($urandom_range(63)), DIDX_W'($urandom_range(127)),
                    rand_coord(), 1'($urandom_range(1)));
          count++;
        end
        send_coord(rand_coord(), (d == nd - 1) ? ($urandom_range(3) == 0)
                                               : ($urandom_range(7) == 0));
        count++;
      end
    drain_results();
  endtask

  task automatic test_random_stream();
    int count;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       set_idling(11, 51);
        1:       set_idling(51, 11);
        default: set_idling(0, 0);
      endcase
      count = 0;
      while (count < RAND_ITEMS / 3) run_random_burst(count);
    end
  endtask

  initial begin
    int waited;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_POINT;
    center_index_i = '0;
    dim_index_i    = '0;
    coord_value_i  = '0;
    last_point_i   = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_NUM_DIMS;
    cfg_data_i     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(11, 51);
    test_center_fill();
    test_reset_defaults();
    test_directed_extremes();
    test_config_extremes();
    test_input_backpressure();
    test_random_stream();

    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    waited = 0;
    while (pending_costs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_costs.size() != 0)
      report_mismatch("results never delivered", 64'(pending_costs.size()), 64'd0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("nearest_center_cost_unit: match");
    else
      $display("nearest_center_cost_unit: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ncc_pkg.sv
rtl/core/ncc_ram.sv
rtl/core/ncc_ctrl.sv
rtl/core/ncc_datapath.sv
rtl/core/nearest_center_cost_unit.sv
tb/sv/tb.sv
